/* rtl/rmlu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmlu_pkg
// Types and codes shared by the recursive monitor lock unit.
// ----------------------------------------------------------------------------
package rmlu_pkg;

  localparam int unsigned TID_W       = 4;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned MAX_THREADS = 16;

  localparam logic [FUNC_W-1:0] FN_ENTER  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_EXIT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_HOLDS  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_WAIT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_NOTIFY = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESUME = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BLOCKED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_OWNER = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  thread_id;
    logic              notify_all;
    logic              cancelled;
  } rmlu_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              holds;
    logic              woken_valid;
    logic [TID_W-1:0]  woken_thread;
    logic              woken_by_condition;
    logic              last;
  } rmlu_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DISPATCH,
    S_SAVE_RD,
    S_GRANT,
    S_SCAN,
    S_SHIFT,
    S_RES_RD,
    S_RES_SET,
    S_NOTIFY,
    S_EMIT
  } rmlu_state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic grant;
    logic scan;
    logic shift;
    logic res_set;
    logic notify_pop;
    logic emit_done;
  } rmlu_cmd_t;

  typedef struct packed {
    logic act_grant;
    logic act_scan;
    logic act_resume;
    logic act_notify;
    logic scan_done;
    logic scan_hit;
    logic shift_done;
    logic notify_more;
    logic out_busy;
  } rmlu_sts_t;

endpackage
`default_nettype wire

/* rtl/rmlu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmlu_ctrl
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module rmlu_ctrl
  import rmlu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rmlu_sts_t sts,
  output rmlu_cmd_t      cmd
);

  rmlu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DECODE;
      S_DECODE:  state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (sts.act_grant) state_nxt = S_SAVE_RD;
        else if (sts.act_scan) state_nxt = S_SCAN;
        else if (sts.act_resume) state_nxt = S_RES_RD;
        else if (sts.act_notify) state_nxt = S_NOTIFY;
        else state_nxt = S_EMIT;
      end
      S_SAVE_RD: state_nxt = S_GRANT;
      S_GRANT:   state_nxt = S_EMIT;
      S_SCAN: begin
        if (sts.scan_hit) state_nxt = S_SHIFT;
        else if (sts.scan_done) state_nxt = S_RES_RD;
      end
      S_SHIFT:   if (sts.shift_done) state_nxt = S_RES_RD;
      S_RES_RD:  state_nxt = S_RES_SET;
      S_RES_SET: state_nxt = S_EMIT;
      S_NOTIFY: begin
        if (!sts.out_busy && !sts.notify_more) state_nxt = S_IDLE;
      end
      S_EMIT:    if (!sts.out_busy) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE:  cmd.decode = 1'b1;
      S_GRANT:   cmd.grant = 1'b1;
      S_SCAN:    cmd.scan = 1'b1;
      S_SHIFT:   cmd.shift = 1'b1;
      S_RES_SET: cmd.res_set = 1'b1;
      S_NOTIFY:  cmd.notify_pop = !sts.out_busy;
      S_EMIT:    cmd.emit_done = !sts.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rmlu_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmlu_dp
// Monitor state, queues, saved counts and result register.
// ----------------------------------------------------------------------------
module rmlu_dp
  import rmlu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rmlu_in_t  in_data,
  input  wire rmlu_cmd_t cmd,
  output rmlu_sts_t      sts,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rmlu_out_t      out_data
);

  localparam int unsigned QD = MAX_THREADS;
  localparam int unsigned QW = $clog2(QD);
  localparam int unsigned CW = $clog2(QD + 1);
  localparam int unsigned SW = $clog2(MAX_THREADS);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [CW-1:0] QFULL = CW'(QD);
  localparam logic [4:0] WAKE_LIM = 5'd16;

  rmlu_in_t req_r;
  logic holder_valid_r;
  logic [TID_W-1:0] holder_r;
  logic [COUNT_WIDTH-1:0] rcount_r;
  logic [TID_W-1:0] entry_q [QD];
  logic [QW-1:0] ehead_r;
  logic [CW-1:0] ecount_r;
  logic [TID_W-1:0] cond_q [QD];
  logic [CW-1:0] ccount_r;
  logic [COUNT_WIDTH-1:0] saved_mem [MAX_THREADS];
  logic [COUNT_WIDTH-1:0] saved_rd_r;
  logic [CW-1:0] idx_r;
  logic [STAT_W-1:0] status_r;
  logic holds_r;
  logic act_grant_r, act_scan_r, act_resume_r, act_notify_r;
  logic [4:0] wakes_r;
  logic [TID_W-1:0] grant_tid_r;
  logic out_valid_r;
  rmlu_out_t out_r;

  logic is_holder, efull, cfull;
  logic [QW-1:0] etail;
  logic [SW-1:0] rd_slot;
  logic save_we;
  logic [SW-1:0] save_slot;
  logic [COUNT_WIDTH-1:0] save_val;

  assign is_holder = holder_valid_r && (holder_r == req_r.thread_id);
  assign efull = (ecount_r >= QFULL);
  assign cfull = (ccount_r >= QFULL);
  assign etail = QW'((CW'(ehead_r) + ecount_r) % QD);
  assign rd_slot = act_grant_r ? SW'(grant_tid_r % MAX_THREADS)
                               : SW'(req_r.thread_id % MAX_THREADS);

  always_comb begin
    save_we = 1'b0;
    save_slot = SW'(req_r.thread_id % MAX_THREADS);
    save_val = rcount_r;
    if (cmd.decode) begin
      if (req_r.func == FN_ENTER && holder_valid_r && !is_holder && !efull) begin
        save_we = 1'b1;
        save_val = '0;
      end else if (req_r.func == FN_WAIT && is_holder && !cfull) begin
        save_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (save_we) saved_mem[save_slot] <= save_val;
    saved_rd_r <= saved_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holder_valid_r <= 1'b0;
      holder_r <= '0;
      rcount_r <= '0;
      ehead_r <= '0;
      ecount_r <= '0;
      ccount_r <= '0;
      idx_r <= '0;
      status_r <= ST_DONE;
      holds_r <= 1'b0;
      act_grant_r <= 1'b0;
      act_scan_r <= 1'b0;
      act_resume_r <= 1'b0;
      act_notify_r <= 1'b0;
      wakes_r <= '0;
      grant_tid_r <= '0;
      out_valid_r <= 1'b0;
      out_r <= '0;
    end else begin
      if (cmd.notify_pop || cmd.emit_done) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load) begin
        act_grant_r <= 1'b0;
        act_scan_r <= 1'b0;
        act_resume_r <= 1'b0;
        act_notify_r <= 1'b0;
        status_r <= ST_DONE;
        holds_r <= 1'b0;
        idx_r <= '0;
        wakes_r <= '0;
      end
      if (cmd.decode) begin
        case (req_r.func)
          FN_ENTER: begin
            if (!holder_valid_r) begin
              holder_valid_r <= 1'b1;
              holder_r <= req_r.thread_id;
              rcount_r <= '0;
            end else if (is_holder) begin
              if (rcount_r == CMAX) status_r <= ST_FULL;
              else rcount_r <= rcount_r + 1'b1;
            end else if (!efull) begin
              entry_q[etail] <= req_r.thread_id;
              ecount_r <= ecount_r + 1'b1;
              status_r <= ST_BLOCKED;
            end else begin
              status_r <= ST_FULL;
            end
          end
          FN_EXIT: begin
            if (!is_holder) status_r <= ST_NOT_OWNER;
            else if (rcount_r != '0) rcount_r <= rcount_r - 1'b1;
            else if (ecount_r == '0) begin
              holder_valid_r <= 1'b0;
              holder_r <= '0;
            end else begin
              grant_tid_r <= entry_q[ehead_r];
              act_grant_r <= 1'b1;
            end
          end
          FN_HOLDS: holds_r <= is_holder;
          FN_WAIT: begin
            if (!is_holder) status_r <= ST_NOT_OWNER;
            else if (cfull) status_r <= ST_FULL;
            else begin
              cond_q[ccount_r[QW-1:0]] <= req_r.thread_id;
              ccount_r <= ccount_r + 1'b1;
              status_r <= ST_BLOCKED;
              rcount_r <= '0;
              if (ecount_r == '0) begin
                holder_valid_r <= 1'b0;
                holder_r <= '0;
              end else begin
                grant_tid_r <= entry_q[ehead_r];
                act_grant_r <= 1'b1;
              end
            end
          end
          FN_NOTIFY: act_notify_r <= 1'b1;
          FN_RESUME: begin
            if (req_r.cancelled) act_scan_r <= 1'b1;
            else act_resume_r <= 1'b1;
          end
          default: status_r <= ST_DONE;
        endcase
      end
      if (cmd.grant) begin
        ehead_r <= QW'((CW'(ehead_r) + 1'b1) % QD);
        ecount_r <= ecount_r - 1'b1;
        holder_valid_r <= 1'b1;
        holder_r <= grant_tid_r;
        rcount_r <= saved_rd_r;
      end
      if (cmd.scan) begin
        if (!(idx_r >= ccount_r) && cond_q[idx_r[QW-1:0]] == req_r.thread_id) begin
          ccount_r <= ccount_r - 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.shift) begin
        if (!(CW'(idx_r + 1'b1) > ccount_r)) begin
          if (idx_r < QFULL - 1'b1)
            cond_q[idx_r[QW-1:0]] <= cond_q[QW'(idx_r + 1'b1)];
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.res_set) begin
        if (!holder_valid_r || holder_r == req_r.thread_id) begin
          holder_valid_r <= 1'b1;
          holder_r <= req_r.thread_id;
          rcount_r <= saved_rd_r;
        end else if (!efull) begin
          entry_q[etail] <= req_r.thread_id;
          ecount_r <= ecount_r + 1'b1;
          status_r <= ST_BLOCKED;
        end else begin
          status_r <= ST_FULL;
        end
      end
      if (cmd.notify_pop) begin
        out_r.status <= ST_DONE;
        out_r.holds <= 1'b0;
        if (ccount_r == '0) begin
          out_r.woken_valid <= 1'b0;
          out_r.woken_thread <= '0;
          out_r.woken_by_condition <= 1'b0;
          out_r.last <= 1'b1;
        end else begin
          for (int i = 0; i < QD - 1; i++) cond_q[i] <= cond_q[i+1];
          ccount_r <= ccount_r - 1'b1;
          wakes_r <= wakes_r + 1'b1;
          out_r.woken_valid <= 1'b1;
          out_r.woken_thread <= cond_q[0];
          out_r.woken_by_condition <= 1'b1;
          out_r.last <= !req_r.notify_all || (ccount_r == CW'(1))
                        || (wakes_r + 1'b1 == WAKE_LIM);
        end
      end
      if (cmd.emit_done) begin
        out_r.status <= status_r;
        out_r.holds <= holds_r;
        out_r.woken_valid <= act_grant_r;
        out_r.woken_thread <= act_grant_r ? grant_tid_r : '0;
        out_r.woken_by_condition <= 1'b0;
        out_r.last <= 1'b1;
      end
    end
  end

  assign sts.act_grant = act_grant_r;
  assign sts.act_scan = act_scan_r;
  assign sts.act_resume = act_resume_r;
  assign sts.act_notify = act_notify_r;
  assign sts.scan_done = (idx_r >= ccount_r);
  assign sts.scan_hit = !(idx_r >= ccount_r) && (cond_q[idx_r[QW-1:0]] == req_r.thread_id);
  assign sts.shift_done = (CW'(idx_r + 1'b1) > ccount_r);
  assign sts.notify_more = req_r.notify_all && (ccount_r > CW'(1))
                           && (wakes_r + 1'b1 != WAKE_LIM);
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assert property (@(posedge clk) disable iff (!rst_n) ecount_r <= QFULL)
    else $error("entry count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) ccount_r <= QFULL)
    else $error("condition count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.grant |-> ecount_r != '0)
    else $error("grant from empty entry queue");

endmodule
`default_nettype wire

/* rtl/recursive_monitor_lock_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_monitor_lock_unit
// Lock manager for one recursive monitor and its condition.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only while the unit is
// idle. A simple request goes from S_IDLE through S_DECODE and S_DISPATCH to
// S_EMIT, where its result is loaded. A grant to an entry waiter adds the
// S_SAVE_RD and S_GRANT states, and a resume the S_RES_RD and S_RES_SET states,
// for the saved-count memory read. A cancelled resume first walks the
// condition list, one entry per cycle. Notify emits one wake result per
// cycle while out_ready is high, up to 16. Every result waits while out_ready
// is low, and the next request is not taken until the last result of the
// current one is in the output register.
module recursive_monitor_lock_unit
  import rmlu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rmlu_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rmlu_out_t     out_data
);

  rmlu_cmd_t cmd;
  rmlu_sts_t sts;

  rmlu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  rmlu_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

/* verif/recursive_monitor_lock_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_monitor_lock_unit_tb
// Self-checking testbench for the recursive monitor lock unit.
// Requests go in through a bursty driver. A monitor compares every result
// transfer with a lock-state predictor kept in the testbench. The stimulus
// is a directed opening, then random thread scenarios, with random output
// stalls and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module recursive_monitor_lock_unit_tb;
  import rmlu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NTHR = 16;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam int unsigned WAKE_LIMIT = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  rmlu_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rmlu_out_t out_data;

  recursive_monitor_lock_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted lock state.
  logic                holder_on;
  logic [3:0]          holder_id;
  logic [15:0]         depth;
  logic [3:0]          entry_q[$];
  logic [3:0]          cond_q[$];
  logic [15:0]         saved_depth[NTHR];
  bit                  saved_known[NTHR];

  rmlu_in_t  pending_reqs[$];
  rmlu_out_t expected_results[$];
  int        errors = 0;
  int        results_seen = 0;
  int        wakes_seen = 0;
  int        cycles = 0;
  bit        stim_done = 1'b0;
  bit        hold_off = 1'b0;

  task automatic report(input string what, input rmlu_out_t got, input rmlu_out_t exp);
    errors++;
    $display("MISMATCH %s: got %p expected %p", what, got, exp);
  endtask

  function automatic logic [3:0] rnd_tid();
    return 4'($urandom_range(15, 0));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(1, 0));
  endfunction

  // Predicts all results of one accepted request and updates the lock state.
  task automatic predict_lock(input rmlu_in_t r);
    logic [1:0] st;
    logic       hq;
    logic [3:0] wid[$];
    logic       wcond[$];
    rmlu_out_t  o;
    int         n;
    st = ST_DONE;
    hq = 1'b0;
    case (r.func)
      FN_ENTER: begin
        if (!holder_on) begin
          holder_on = 1'b1; holder_id = r.thread_id; depth = '0;
        end else if (holder_id == r.thread_id) begin
          if (depth == CNT_MAX) st = ST_FULL;
          else depth++;
        end else if (entry_q.size() < NTHR) begin
          entry_q.push_back(r.thread_id);
          saved_depth[r.thread_id] = '0;
          saved_known[r.thread_id] = 1'b1;
          st = ST_BLOCKED;
        end else st = ST_FULL;
      end
      FN_EXIT, FN_WAIT: begin
        if (!(holder_on && holder_id == r.thread_id)) st = ST_NOT_OWNER;
        else if (r.func == FN_EXIT && depth != '0) depth--;
        else if (r.func == FN_WAIT && cond_q.size() >= NTHR) st = ST_FULL;
        else begin
          if (r.func == FN_WAIT) begin
            cond_q.push_back(r.thread_id);
            saved_depth[r.thread_id] = depth;
            saved_known[r.thread_id] = 1'b1;
            st = ST_BLOCKED;
          end
          if (entry_q.size() == 0) begin
            holder_on = 1'b0; holder_id = '0; depth = '0;
          end else begin
            holder_id = entry_q.pop_front();
            depth = saved_depth[holder_id];
            wid.push_back(holder_id); wcond.push_back(1'b0);
          end
        end
      end
      FN_HOLDS: hq = holder_on && holder_id == r.thread_id;
      FN_NOTIFY: begin
        while (cond_q.size() > 0 && wid.size() < WAKE_LIMIT) begin
          wid.push_back(cond_q.pop_front()); wcond.push_back(1'b1);
          if (!r.notify_all) break;
        end
      end
      FN_RESUME: begin
        if (r.cancelled) begin
          foreach (cond_q[i]) begin
            if (cond_q[i] == r.thread_id) begin
              cond_q.delete(i);
              break;
            end
          end
        end
        if (!holder_on || holder_id == r.thread_id) begin
          holder_on = 1'b1; holder_id = r.thread_id;
          depth = saved_depth[r.thread_id];
        end else if (entry_q.size() < NTHR) begin
          entry_q.push_back(r.thread_id); st = ST_BLOCKED;
        end else st = ST_FULL;
      end
      default: ;
    endcase
    n = wid.size() > 0 ? wid.size() : 1;
    for (int k = 0; k < n; k++) begin
      o = '0;
      o.status = st;
      o.holds = hq;
      if (wid.size() > 0) begin
        o.woken_valid = 1'b1; o.woken_thread = wid[k]; o.woken_by_condition = wcond[k];
      end
      o.last = (k == n - 1);
      expected_results.push_back(o);
    end
  endtask

  // Stimulus builder keeps a shadow of the state so that a never-written
  // saved count is not read by a grant or resume.
  rmlu_in_t  plan[$];
  logic      sh_on;
  logic [3:0] sh_id;
  logic [15:0] sh_depth;
  logic [3:0] sh_entry[$];
  logic [3:0] sh_cond[$];
  bit        sh_known[NTHR];
  logic [15:0] sh_saved[NTHR];

  // Applies one request to the shadow state and queues it.
  task automatic add_req(input logic [2:0] f, input logic [3:0] t,
                         input logic a, input logic c);
    rmlu_in_t r;
    r.func = f; r.thread_id = t; r.notify_all = a; r.cancelled = c;
    // A resume reads the saved count of its thread, so that count must exist.
    if (f == FN_RESUME && !sh_known[t]) return;
    case (f)
      FN_ENTER: begin
        if (!sh_on) begin sh_on = 1'b1; sh_id = t; sh_depth = '0; end
        else if (sh_id == t) begin if (sh_depth != CNT_MAX) sh_depth++; end
        else if (sh_entry.size() < NTHR) begin
          sh_entry.push_back(t); sh_known[t] = 1'b1; sh_saved[t] = '0;
        end
      end
      FN_EXIT, FN_WAIT: begin
        if (sh_on && sh_id == t) begin
          if (f == FN_EXIT && sh_depth != '0) sh_depth--;
          else if (!(f == FN_WAIT && sh_cond.size() >= NTHR)) begin
            if (f == FN_WAIT) begin
              sh_cond.push_back(t); sh_known[t] = 1'b1; sh_saved[t] = sh_depth;
            end
            if (sh_entry.size() == 0) sh_on = 1'b0;
            else begin sh_id = sh_entry.pop_front(); sh_depth = sh_saved[sh_id]; end
          end
        end
      end
      FN_NOTIFY: begin
        for (int k = 0; k < WAKE_LIMIT && sh_cond.size() > 0; k++) begin
          void'(sh_cond.pop_front());
          if (!a) break;
        end
      end
      FN_RESUME: begin
        if (c) foreach (sh_cond[i]) if (sh_cond[i] == t) begin sh_cond.delete(i); break; end
        if (!sh_on || sh_id == t) begin sh_on = 1'b1; sh_id = t; sh_depth = sh_saved[t]; end
        else if (sh_entry.size() < NTHR) sh_entry.push_back(t);
      end
      default: ;
    endcase
    plan.push_back(r);
  endtask

  // Driver: bursts of transfers separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        void'(pending_reqs.pop_front());
        predict_lock(in_data);
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left <= int'($urandom_range(12, 1));
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(20, 1));
        end else burst_left <= burst_left - 1;
      end else in_valid <= 1'b0;
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_data.woken_valid) wakes_seen <= wakes_seen + 1;
        if (expected_results.size() == 0) report("unexpected result", out_data, '0);
        else begin
          rmlu_out_t e;
          e = expected_results.pop_front();
          if (out_data.status !== e.status) report("status", out_data, e);
          if (out_data.holds !== e.holds) report("holds", out_data, e);
          if (out_data.woken_valid !== e.woken_valid) report("woken_valid", out_data, e);
          if (out_data.woken_thread !== e.woken_thread) report("woken_thread", out_data, e);
          if (out_data.woken_by_condition !== e.woken_by_condition)
            report("woken_by_condition", out_data, e);
          if (out_data.last !== e.last) report("last", out_data, e);
        end
      end
      stall_phase <= (stall_phase + 1) % 23;
      if (hold_off) out_ready <= 1'b0;
      else if (stall_phase < 6) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(3, 0) != 0);
    end
  end

  // Long result-side hold-off while the sender keeps offering.
  initial begin
    wait (stim_done);
    repeat (200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [2:0] f;
    logic [3:0] t;
    for (int i = 0; i < NTHR; i++) begin sh_known[i] = 1'b0; sh_saved[i] = '0; end
    for (int i = 0; i < NTHR; i++) begin saved_depth[i] = '0; saved_known[i] = 1'b0; end
    sh_on = 1'b0; sh_id = '0; sh_depth = '0;
    holder_on = 1'b0; holder_id = '0; depth = '0;
    // Directed opening: non-owner exit with no holder, unknown func, queries,
    // recursion, entry hand-off, wait/notify, cancelled and plain resume.
    add_req(FN_EXIT, 4'd0, 1'b0, 1'b0);
    add_req(FN_WAIT, 4'd15, 1'b1, 1'b1);
    add_req(3'd6, 4'd5, 1'b0, 1'b0);
    add_req(3'd7, 4'd10, 1'b1, 1'b1);
    add_req(FN_NOTIFY, 4'd3, 1'b1, 1'b0);
    add_req(FN_ENTER, 4'd0, 1'b0, 1'b0);
    add_req(FN_ENTER, 4'd0, 1'b0, 1'b0);
    add_req(FN_HOLDS, 4'd0, 1'b0, 1'b0);
    add_req(FN_HOLDS, 4'd15, 1'b0, 1'b0);
    add_req(FN_ENTER, 4'd15, 1'b0, 1'b0);
    add_req(FN_EXIT, 4'd15, 1'b0, 1'b0);
    add_req(FN_WAIT, 4'd0, 1'b0, 1'b0);
    add_req(FN_WAIT, 4'd15, 1'b0, 1'b0);
    add_req(FN_NOTIFY, 4'd7, 1'b0, 1'b0);
    add_req(FN_NOTIFY, 4'd7, 1'b1, 1'b0);
    add_req(FN_RESUME, 4'd15, 1'b0, 1'b1);
    add_req(FN_RESUME, 4'd0, 1'b0, 1'b0);
    add_req(FN_EXIT, 4'd0, 1'b0, 1'b0);
    add_req(FN_EXIT, 4'd0, 1'b0, 1'b0);
    add_req(FN_EXIT, 4'd15, 1'b0, 1'b0);
    add_req(FN_EXIT, 4'd15, 1'b0, 1'b0);
    // Random part: mostly enter/wait/notify/resume scenarios across threads.
    while (plan.size() < 420) begin
      case ($urandom_range(9, 0))
        0, 1: add_req(FN_ENTER, rnd_tid(), rnd_bit(), rnd_bit());
        2: add_req(FN_EXIT, (sh_on && $urandom_range(3, 0) != 0) ? sh_id : rnd_tid(),
                   rnd_bit(), rnd_bit());
        3: add_req(FN_WAIT, (sh_on && $urandom_range(4, 0) != 0) ? sh_id : rnd_tid(),
                   rnd_bit(), rnd_bit());
        4: add_req(FN_NOTIFY, rnd_tid(), rnd_bit(), rnd_bit());
        5, 6: begin
          t = rnd_tid();
          if (sh_known[t])
            add_req(FN_RESUME, t, rnd_bit(), rnd_bit());
        end
        7: add_req(FN_HOLDS, rnd_tid(), rnd_bit(), rnd_bit());
        8: begin
          // Each thread enters in turn and waits if it then holds the lock; then wake all waiters.
          for (int k = 0; k < 16; k++) begin
            t = 4'(k);
            add_req(FN_ENTER, t, 1'b0, 1'b0);
            if (sh_on && sh_id == t) add_req(FN_WAIT, t, 1'b0, 1'b0);
          end
          add_req(FN_NOTIFY, rnd_tid(), 1'b1, 1'b0);
        end
        default: begin
          f = 3'($urandom_range(7, 0));
          t = rnd_tid();
          if (f != FN_RESUME) add_req(f, t, rnd_bit(), rnd_bit());
        end
      endcase
    end
    repeat (12) @(posedge clk);
    pending_reqs = plan;
    rst_n <= 1'b1;
    stim_done = 1'b1;
    while ((pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid) &&
           cycles < CYCLE_LIMIT)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("recursive_monitor_lock_unit test failed");
    end else begin
      $display("Covered %0d requests, %0d results of which %0d named a woken thread.",
               plan.size(), results_seen, wakes_seen);
      if (errors == 0 && expected_results.size() == 0)
        $display("recursive_monitor_lock_unit test passed");
      else
        $display("recursive_monitor_lock_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
